/* hdl/pinch_gesture_detector_assert.svh */
// assertion macros for the pinch detector tracking module
`ifndef PINCH_GESTURE_DETECTOR_ASSERT_SVH
`define PINCH_GESTURE_DETECTOR_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define PGD_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("pinch detector check failed");

// condition holds in the cycle after the trigger
`define PGD_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("pinch detector check failed");

`endif

/* hdl/pgd_pkg.sv */
// types and constants of the pinch gesture detector
package pgd_pkg;

    localparam int LINE_BITS  = 6;
    localparam int LINE_COUNT = 6;
    localparam int GAP_W      = 3;
    localparam int CHANGE_W   = 4;

    typedef enum logic
    {
        GESTURE_ZOOM_IN  = 1'b0,
        GESTURE_ZOOM_OUT = 1'b1
    } gesture_t;

    // summary of one sample of the sensor lines
    typedef struct packed
    {
        logic             multi;
        logic             any;
        logic [GAP_W-1:0] gap;
    } scan_t;

endpackage

/* hdl/pgd_if.sv */
// channel interfaces for touch samples and gesture results
interface pgd_touch_if;
    logic                           valid;
    logic                           ready;
    logic [pgd_pkg::LINE_BITS-1:0]  touch_lines;

    modport source (output valid, output touch_lines, input ready);
    modport sink (input valid, input touch_lines, output ready);
endinterface

interface pgd_gesture_if;
    logic                                valid;
    logic                                ready;
    logic                                gesture;
    logic signed [pgd_pkg::CHANGE_W-1:0] gap_change;

    modport source (output valid, output gesture, output gap_change, input ready);
    modport sink (input valid, input gesture, input gap_change, output ready);
endinterface

/* hdl/pgd_scan.sv */
// finds the gap between the two lowest touched lines of one sample
module pgd_scan #(
    parameter int SCAN_W = pgd_pkg::LINE_COUNT
) (
    input  logic [SCAN_W-1:0] lines,
    output pgd_pkg::scan_t    scan
);

    logic [1:0]                   seen;
    logic [pgd_pkg::GAP_W-1:0]    first;
    logic [pgd_pkg::GAP_W-1:0]    gap;

    always_comb
    begin
        seen  = 2'd0;
        first = '0;
        gap   = '0;
        for (int i = 0; i < SCAN_W; i++)
        begin
            if (lines[i])
            begin
                if (seen == 2'd0)
                begin
                    first = pgd_pkg::GAP_W'(i);
                end
                else if (seen == 2'd1)
                begin
                    gap = pgd_pkg::GAP_W'(i) - first;
                end
                // saturate at two, only the two lowest lines count
                if (seen != 2'd2)
                begin
                    seen = seen + 2'd1;
                end
            end
        end
        scan.multi = (seen == 2'd2);
        scan.any   = (seen != 2'd0);
        scan.gap   = gap;
    end

endmodule

/* hdl/pgd_track.sv */
// gesture state and result register
`include "pinch_gesture_detector_assert.svh"

module pgd_track (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  pgd_pkg::scan_t         scan,
    output logic                   can_take,
    pgd_gesture_if.source          pinch
);

    logic                                tracking_reg, tracking_next;
    logic [pgd_pkg::GAP_W-1:0]           start_gap_reg, start_gap_next;
    logic [pgd_pkg::GAP_W-1:0]           latest_gap_reg, latest_gap_next;
    logic                                out_valid_reg, out_valid_next;
    pgd_pkg::gesture_t                   gesture_reg, gesture_next;
    logic signed [pgd_pkg::CHANGE_W-1:0] change_reg, change_next;
    logic signed [pgd_pkg::CHANGE_W-1:0] diff;

    // result slot is free or being emptied this cycle
    assign can_take = !out_valid_reg || pinch.ready;

    assign diff = $signed({1'b0, latest_gap_reg}) - $signed({1'b0, start_gap_reg});

    always_comb
    begin
        tracking_next   = tracking_reg;
        start_gap_next  = start_gap_reg;
        latest_gap_next = latest_gap_reg;
        out_valid_next  = out_valid_reg && !pinch.ready;
        gesture_next    = gesture_reg;
        change_next     = change_reg;
        if (step)
        begin
            if (!tracking_reg)
            begin
                if (scan.multi)
                begin
                    start_gap_next  = scan.gap;
                    latest_gap_next = scan.gap;
                    tracking_next   = 1'b1;
                end
            end
            else if (scan.multi)
            begin
                latest_gap_next = scan.gap;
            end
            else if (!scan.any)
            begin
                // release ends the gesture, unchanged gap reports nothing
                tracking_next = 1'b0;
                if (latest_gap_reg != start_gap_reg)
                begin
                    out_valid_next = 1'b1;
                    change_next    = diff;
                    gesture_next   = (latest_gap_reg > start_gap_reg) ?
                                     pgd_pkg::GESTURE_ZOOM_IN : pgd_pkg::GESTURE_ZOOM_OUT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg   <= 1'b0;
            start_gap_reg  <= '0;
            latest_gap_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tracking_reg   <= tracking_next;
            start_gap_reg  <= start_gap_next;
            latest_gap_reg <= latest_gap_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gesture_reg <= gesture_next;
        change_reg  <= change_next;
    end

    assign pinch.valid      = out_valid_reg;
    assign pinch.gesture    = gesture_reg;
    assign pinch.gap_change = change_reg;

    `PGD_ASSERT_NOW(a_change_nonzero, out_valid_reg, change_reg != '0)
    `PGD_ASSERT_NOW(a_sign_matches, out_valid_reg,
        (gesture_reg == pgd_pkg::GESTURE_ZOOM_OUT) == change_reg[pgd_pkg::CHANGE_W-1])
    `PGD_ASSERT_NOW(a_emit_ends_gesture, $rose(out_valid_reg), !tracking_reg)
    `PGD_ASSERT_NOW(a_start_held, tracking_reg && $past(tracking_reg),
        $stable(start_gap_reg))
    `PGD_ASSERT_NEXT(a_no_step_when_full, out_valid_reg && !pinch.ready && !step,
        out_valid_reg)

endmodule

/* hdl/pinch_gesture_detector.sv */
// pinch detector top level: sample register, line scan and gesture tracking
// order: the release sample passes the sample register, then the result register drives pinch
// throughput: one sample per cycle; a held result stalls the sample register
// and the input stalls only while that register is full and the result is held
// reset: asynchronous, active low; the block returns to watching with both gaps zero
module pinch_gesture_detector #(
    parameter int LINE_COUNT = pgd_pkg::LINE_COUNT
) (
    input  logic          clk,
    input  logic          rst_n,
    pgd_touch_if.sink     sample,
    pgd_gesture_if.source pinch
);

    localparam int SCAN_W = (LINE_COUNT < pgd_pkg::LINE_BITS) ?
                            LINE_COUNT : pgd_pkg::LINE_BITS;

    logic              in_valid_reg, in_valid_next;
    logic [SCAN_W-1:0] lines_reg, lines_next;
    logic              can_take;
    logic              step;
    pgd_pkg::scan_t    scan;

    assign step         = in_valid_reg && can_take;
    assign sample.ready = !in_valid_reg || can_take;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        lines_next    = lines_reg;
        if (sample.ready)
        begin
            in_valid_next = sample.valid;
            lines_next    = sample.touch_lines[SCAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lines_reg <= lines_next;
    end

    pgd_scan #(
        .SCAN_W (SCAN_W)
    ) u_scan (
        .lines (lines_reg),
        .scan  (scan)
    );

    pgd_track u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .scan     (scan),
        .can_take (can_take),
        .pinch    (pinch)
    );

endmodule

/* dv/tb_pinch_gesture_detector.sv */
// self-checking testbench for the pinch gesture detector
`timescale 1ns / 100ps

module tb_pinch_gesture_detector;

    localparam int SCAN_LINES  = (pgd_pkg::LINE_COUNT < pgd_pkg::LINE_BITS) ?
                                 pgd_pkg::LINE_COUNT : pgd_pkg::LINE_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_SAMPLES = 1450;

    typedef struct
    {
        pgd_pkg::gesture_t                    gesture;
        logic signed [pgd_pkg::CHANGE_W-1:0]  change;
    } pinch_result_t;

    logic clk;
    logic rst_n;

    pgd_touch_if   sample_bus ();
    pgd_gesture_if pinch_bus ();

    pinch_gesture_detector dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .pinch  (pinch_bus)
    );

    // own copy of the gesture state
    logic                          tracking;
    logic [pgd_pkg::GAP_W-1:0]     start_gap;
    logic [pgd_pkg::GAP_W-1:0]     latest_gap;

    pinch_result_t pending_gestures[$];
    pinch_result_t got_result;
    pinch_result_t want_result;

    int  mismatch_count = 0;
    int  samples_sent   = 0;
    int  cycle_count    = 0;
    int  stall_left     = 0;
    bit  source_idle_on = 1'b1;
    bit  sink_idle_on   = 1'b1;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // works out the result of one accepted sample
    task automatic track_pinch(input logic [pgd_pkg::LINE_BITS-1:0] lines);
        int                        touched;
        int                        first;
        logic [pgd_pkg::GAP_W-1:0] gap;
        pinch_result_t             res;
        touched = 0;
        first   = 0;
        gap     = '0;
        for (int i = 0; i < SCAN_LINES; i++)
        begin
            if (lines[i])
            begin
                if (touched == 0)
                    first = i;
                else if (touched == 1)
                    gap = pgd_pkg::GAP_W'(i - first);
                touched++;
            end
        end
        if (!tracking)
        begin
            if (touched >= 2)
            begin
                start_gap  = gap;
                latest_gap = gap;
                tracking   = 1'b1;
            end
        end
        else if (touched >= 2)
            latest_gap = gap;
        else if (touched == 0)
        begin
            tracking = 1'b0;
            if (latest_gap != start_gap)
            begin
                res.gesture = (latest_gap > start_gap) ? pgd_pkg::GESTURE_ZOOM_IN :
                                                         pgd_pkg::GESTURE_ZOOM_OUT;
                res.change  = pgd_pkg::CHANGE_W'(latest_gap) -
                              pgd_pkg::CHANGE_W'(start_gap);
                pending_gestures.push_back(res);
            end
        end
    endtask

    // offers one sample and returns at the edge of its transfer; valid stays high
    task automatic send_sample(input logic [pgd_pkg::LINE_BITS-1:0] lines);
        while (source_idle_on && $urandom_range(0, 99) < 29)
        begin
            sample_bus.valid       <= 1'b0;
            sample_bus.touch_lines <= pgd_pkg::LINE_BITS'($urandom);
            @(posedge clk);
        end
        sample_bus.valid       <= 1'b1;
        sample_bus.touch_lines <= lines;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        track_pinch(lines);
        samples_sent++;
    endtask

    task automatic wait_for_results();
        sample_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_gestures.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [pgd_pkg::LINE_BITS-1:0] lines_with_gap(input int gap);
        int lo;
        lo = $urandom_range(0, pgd_pkg::LINE_BITS - 1 - gap);
        return pgd_pkg::LINE_BITS'((1 << lo) | (1 << (lo + gap)));
    endfunction

    // two lowest touches at random, any lines above them may be touched too
    function automatic logic [pgd_pkg::LINE_BITS-1:0] random_multi();
        int                            lo;
        int                            hi;
        logic [pgd_pkg::LINE_BITS-1:0] above;
        lo    = $urandom_range(0, pgd_pkg::LINE_BITS - 2);
        hi    = $urandom_range(lo + 1, pgd_pkg::LINE_BITS - 1);
        above = pgd_pkg::LINE_BITS'($urandom) &
                ~pgd_pkg::LINE_BITS'((1 << (hi + 1)) - 1);
        return pgd_pkg::LINE_BITS'((1 << lo) | (1 << hi)) | above;
    endfunction

    function automatic logic [pgd_pkg::LINE_BITS-1:0] random_single();
        return pgd_pkg::LINE_BITS'(1 << $urandom_range(0, pgd_pkg::LINE_BITS - 1));
    endfunction

    task automatic test_watching_noise();
        send_sample(6'b000000);
        send_sample(6'b000001);
        send_sample(6'b100000);
        send_sample(6'b000000);
    endtask

    task automatic test_spread_and_close();
        // widest spread, then widest close with a single touch in the middle
        send_sample(6'b000011);
        send_sample(6'b100001);
        send_sample(6'b000000);
        send_sample(6'b100001);
        send_sample(6'b000100);
        send_sample(6'b110000);
        send_sample(6'b000000);
    endtask

    task automatic test_crowded_lines();
        // only the two lowest lines count; equal gaps give nothing
        send_sample(6'b111111);
        send_sample(6'b101011);
        send_sample(6'b000000);
        send_sample(6'b010100);
        send_sample(6'b001001);
        send_sample(6'b000000);
    endtask

    // results held back while the source keeps offering, then a full drain
    task automatic test_backpressure();
        int s;
        int l;
        stall_left = 160;
        repeat (20)
        begin
            s = $urandom_range(1, pgd_pkg::LINE_BITS - 1);
            l = $urandom_range(1, pgd_pkg::LINE_BITS - 2);
            if (l >= s)
                l++;
            send_sample(lines_with_gap(s));
            send_sample(lines_with_gap(l));
            send_sample(6'b000000);
        end
        wait_for_results();
    endtask

    task automatic random_gesture();
        send_sample(random_multi());
        repeat ($urandom_range(0, 4))
        begin
            if ($urandom_range(0, 99) < 80)
                send_sample(random_multi());
            else
                send_sample(random_single());
        end
        // now and then a gesture is left open and broken up by noise
        if ($urandom_range(0, 99) < 90)
            send_sample(6'b000000);
    endtask

    task automatic test_random_gestures(input int target);
        while (samples_sent < target)
        begin
            if ($urandom_range(0, 99) < 12)
                send_sample(pgd_pkg::LINE_BITS'($urandom));
            else
                random_gesture();
            if ($urandom_range(0, 99) < 3)
                wait_for_results();
        end
    endtask

    task automatic test_steady_stream();
        source_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
        test_random_gestures(samples_sent + 300);
        source_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
    endtask

    initial
    begin
        pinch_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                pinch_bus.ready <= 1'b0;
                stall_left--;
            end
            else
                pinch_bus.ready <= !(sink_idle_on && $urandom_range(0, 99) < 29);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pinch_bus.valid && pinch_bus.ready)
        begin
            got_result.gesture = pgd_pkg::gesture_t'(pinch_bus.gesture);
            got_result.change  = pinch_bus.gap_change;
            if (pending_gestures.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual gesture %0d change %0d",
                         $time, got_result.gesture, got_result.change);
                mismatch_count++;
            end
            else
            begin
                want_result = pending_gestures.pop_front();
                if (got_result.gesture !== want_result.gesture)
                begin
                    $display("%0t: gesture mismatch, expected %0d actual %0d",
                             $time, want_result.gesture, got_result.gesture);
                    mismatch_count++;
                end
                if (got_result.change !== want_result.change)
                begin
                    $display("%0t: gap_change mismatch, expected %0d actual %0d",
                             $time, want_result.change, got_result.change);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n                  = 1'b0;
        sample_bus.valid       = 1'b0;
        sample_bus.touch_lines = '0;
        tracking               = 1'b0;
        start_gap              = '0;
        latest_gap             = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_watching_noise();
        test_spread_and_close();
        test_crowded_lines();
        test_backpressure();
        test_random_gestures(samples_sent + 500);
        test_steady_stream();
        test_random_gestures(RANDOM_SAMPLES);

        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_gestures.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/pgd_pkg.sv
hdl/pgd_if.sv
hdl/pgd_scan.sv
hdl/pgd_track.sv
hdl/pinch_gesture_detector.sv
dv/tb_pinch_gesture_detector.sv
